[rtl/core/sha256_pkg.sv]
// shared types, constants and round functions for the sha-256 digest block
// no dependencies
`timescale 1ns / 1ps

package sha256_pkg;

    localparam int WordW   = 32;
    localparam int Rounds  = 64;
    localparam int LenW    = 61;

    localparam logic [7:0] PadByte = 8'h80;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef logic [WordW-1:0] word_t;

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t v;
        begin
            v = '0;
            unique case (idx)
                3'd0: v = 32'h6a09e667;
                3'd1: v = 32'hbb67ae85;
                3'd2: v = 32'h3c6ef372;
                3'd3: v = 32'ha54ff53a;
                3'd4: v = 32'h510e527f;
                3'd5: v = 32'h9b05688c;
                3'd6: v = 32'h1f83d9ab;
                3'd7: v = 32'h5be0cd19;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    function automatic word_t round_k(input logic [5:0] r);
        logic [WordW-1:0] k [64];
        begin
            k = '{
                32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
                32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
                32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
                32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
                32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
                32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
                32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
                32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
                32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
                32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
                32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
                32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
                32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
                32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
                32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
                32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
            };
            return k[r];
        end
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        begin
            return (x >> n) | (x << (WordW - n));
        end
    endfunction

    function automatic word_t sig0(input word_t x);
        begin
            return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
        end
    endfunction

    function automatic word_t sig1(input word_t x);
        begin
            return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
        end
    endfunction

    function automatic word_t bsig0(input word_t x);
        begin
            return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
        end
    endfunction

    function automatic word_t bsig1(input word_t x);
        begin
            return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
        end
    endfunction

endpackage

[rtl/core/sha256_round.sv]
// one sha-256 compression round on registered working variables
// depends on sha256_pkg
`timescale 1ns / 1ps

module sha256_round (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic                         step,
    input  sha256_pkg::word_t            init_vars [8],
    input  sha256_pkg::word_t            w_in,
    input  logic [5:0]                   round,
    output sha256_pkg::word_t            vars [8]
);

    sha256_pkg::word_t vars_reg  [8];
    sha256_pkg::word_t vars_next [8];
    sha256_pkg::word_t t1;
    sha256_pkg::word_t t2;

    always_comb
    begin
        t1 = vars_reg[7] + sha256_pkg::bsig1(vars_reg[4])
           + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
           + sha256_pkg::round_k(round) + w_in;
        t2 = sha256_pkg::bsig0(vars_reg[0])
           + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
              ^ (vars_reg[1] & vars_reg[2]));
        vars_next = vars_reg;
        if (load)
        begin
            vars_next = init_vars;
        end
        else if (step)
        begin
            for (int k = 7; k > 0; k--)
            begin
                vars_next[k] = vars_reg[k-1];
            end
            vars_next[4] = vars_reg[3] + t1;
            vars_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 8; k++)
            begin
                vars_reg[k] <= '0;
            end
        end
        else
        begin
            vars_reg <= vars_next;
        end
    end

    assign vars = vars_reg;

endmodule

[rtl/core/sha256_message_digest.sv]
// sha-256 digest of a byte stream, top level
// depends on sha256_pkg and sha256_round
//
//  channel | dir | beat payload                       | note
//  in      | in  | data_byte, byte_valid, message_end  | one byte or end mark per beat
//  out     | out | digest_word, word_index, last_word  | eight beats per message
//
// a byte that does not complete a block is written to the block buffer
// a byte completing a block starts a load, the 64 rounds and a fold; the loop
// computes one round per cycle
// an end beat adds a padding pass, then a load, the rounds and a fold for each of
// one or two padded blocks, then eight output beats
// the output register holds a beat through any stall; reset needs no sweep
`timescale 1ns / 1ps

module sha256_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        message_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    // block buffer as a memory with one write port and one registered read port
    logic [31:0] buf_mem [16];

    sha256_pkg::state_t state_reg, state_next;

    sha256_pkg::word_t hash_reg [8];
    logic [31:0] word_reg;          // word being packed
    logic [5:0]  fill_reg;          // bytes held in block
    logic [sha256_pkg::LenW-1:0] len_reg;
    logic [6:0]  cnt_reg;           // load/round counter
    logic        pad_reg;           // in padding phase
    logic        len_blk_reg;       // current block is the final length block
    logic        extra_reg;         // another zero+length block follows
    logic [2:0]  emit_reg;
    logic        out_valid_reg;

    // schedule pipeline taps (w[t-2], w[t-7], w[t-15], w[t-16]) kept as a shift line
    sha256_pkg::word_t win_reg [16];
    sha256_pkg::word_t w_cur;
    sha256_pkg::word_t vars [8];
    sha256_pkg::word_t init_vars [8];
    logic round_load, round_step;

    logic [31:0] buf_rd_reg;
    logic [3:0]  rd_addr;
    logic        accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == sha256_pkg::ST_FILL) && !pad_reg;

    // next schedule word: from memory in the first 16 rounds, expanded after
    always_comb
    begin
        if (cnt_reg < 7'd16)
        begin
            w_cur = buf_rd_reg;
        end
        else
        begin
            w_cur = sha256_pkg::sig1(win_reg[14]) + win_reg[9]
                  + sha256_pkg::sig0(win_reg[1]) + win_reg[0];
        end
    end

    assign init_vars  = hash_reg;
    assign round_load = (state_reg == sha256_pkg::ST_LOAD);
    assign round_step = (state_reg == sha256_pkg::ST_ROUND);

    sha256_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (round_load),
        .step      (round_step),
        .init_vars (init_vars),
        .w_in      (w_cur),
        .round     (cnt_reg[5:0]),
        .vars      (vars)
    );

    // packed word and write-enable for the block buffer
    logic [31:0] packed_word;
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic [1:0]  bpos;

    always_comb
    begin
        bpos = fill_reg[1:0];
        packed_word = (bpos == 2'd0) ? 32'd0 : word_reg;
        packed_word = packed_word | ({24'd0, (pad_reg ? sha256_pkg::PadByte : data_byte)}
                      << (5'd24 - {bpos, 3'd0}));
        wr_en = 1'b0;
        wr_addr = fill_reg[5:2];
        wr_data = packed_word;
        if (state_reg == sha256_pkg::ST_FILL)
        begin
            if (pad_reg)
            begin
                // padding pass: 0x80, zeros, length words
                wr_en = 1'b1;
                if (len_blk_reg && fill_reg[5:2] == 4'd14)
                begin
                    wr_data = {3'd0, len_reg[60:32]} << 3 | {29'd0, len_reg[31:29]};
                end
                else if (len_blk_reg && fill_reg[5:2] == 4'd15)
                begin
                    wr_data = {len_reg[28:0], 3'd0};
                end
                else if (cnt_reg[0])
                begin
                    wr_data = 32'd0;
                end
            end
            else if (accept && byte_valid)
            begin
                wr_en = 1'b1;
            end
        end
    end

    // the block buffer read address is one word ahead of the round, as the read is registered
    assign rd_addr = round_step ? (cnt_reg[3:0] + 4'd1) : 4'd0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_mem[wr_addr] <= wr_data;
        end
        buf_rd_reg <= buf_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha256_pkg::ST_FILL:
            begin
                if (pad_reg)
                begin
                    if (fill_reg[5:2] == 4'd15)
                    begin
                        state_next = sha256_pkg::ST_LOAD;
                    end
                end
                else if (accept && byte_valid && fill_reg == 6'd63)
                begin
                    state_next = sha256_pkg::ST_LOAD;
                end
            end
            sha256_pkg::ST_LOAD:  state_next = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_ROUND:
            begin
                if (cnt_reg == 7'd63)
                begin
                    state_next = sha256_pkg::ST_FOLD;
                end
            end
            sha256_pkg::ST_FOLD:
            begin
                if (!len_blk_reg)
                begin
                    state_next = sha256_pkg::ST_FILL;
                end
                else
                begin
                    state_next = sha256_pkg::ST_EMIT;
                end
            end
            sha256_pkg::ST_EMIT:
            begin
                if (out_valid_reg && out_ready && emit_reg == 3'd7)
                begin
                    state_next = sha256_pkg::ST_FILL;
                end
            end
            default: state_next = sha256_pkg::ST_FILL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha256_pkg::ST_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 8; k++)
            begin
                hash_reg[k] <= sha256_pkg::init_hash(3'(k));
            end
            word_reg      <= '0;
            fill_reg      <= '0;
            len_reg       <= '0;
            cnt_reg       <= '0;
            pad_reg       <= 1'b0;
            len_blk_reg   <= 1'b0;
            extra_reg     <= 1'b0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                sha256_pkg::ST_FILL:
                begin
                    if (pad_reg)
                    begin
                        // walk words; cnt_reg[0] set once 0x80 is placed
                        if (!cnt_reg[0])
                        begin
                            cnt_reg[0] <= 1'b1;
                        end
                        if (fill_reg[5:2] == 4'd15)
                        begin
                            fill_reg <= '0;
                            cnt_reg  <= '0;
                        end
                        else
                        begin
                            fill_reg <= {fill_reg[5:2] + 4'd1, 2'b00};
                        end
                    end
                    else if (accept)
                    begin
                        if (byte_valid)
                        begin
                            word_reg <= packed_word;
                            fill_reg <= fill_reg + 6'd1;
                            len_reg  <= len_reg + 61'd1;
                        end
                        if (message_end)
                        begin
                            // start padding after this byte
                            pad_reg <= 1'b1;
                            if (byte_valid)
                            begin
                                len_reg <= len_reg + 61'd1;
                                if (fill_reg == 6'd63)
                                begin
                                    // block full: compress first, pad into a fresh block
                                    fill_reg <= '0;
                                    word_reg <= packed_word;
                                end
                            end
                            begin
                                logic [5:0] nf;
                                nf = byte_valid ? fill_reg + 6'd1 : fill_reg;
                                if (byte_valid && fill_reg == 6'd63)
                                begin
                                    // 0x80 and the length follow after the fold
                                    len_blk_reg <= 1'b0;
                                    extra_reg   <= 1'b0;
                                    cnt_reg     <= '0;
                                end
                                else
                                begin
                                    len_blk_reg <= (nf < 6'd56);
                                    extra_reg   <= (nf >= 6'd56);
                                    cnt_reg     <= '0;
                                end
                            end
                        end
                        else if (byte_valid && fill_reg == 6'd63)
                        begin
                            cnt_reg <= '0;
                        end
                    end
                end
                sha256_pkg::ST_LOAD:
                begin
                    cnt_reg <= '0;
                end
                sha256_pkg::ST_ROUND:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                end
                sha256_pkg::ST_FOLD:
                begin
                    for (int k = 0; k < 8; k++)
                    begin
                        hash_reg[k] <= hash_reg[k] + vars[k];
                    end
                    cnt_reg <= '0;
                    if (len_blk_reg)
                    begin
                        pad_reg       <= 1'b0;
                        emit_reg      <= '0;
                        out_valid_reg <= 1'b1;
                    end
                    else if (extra_reg)
                    begin
                        // second pad block: all zero but the length
                        extra_reg   <= 1'b0;
                        len_blk_reg <= 1'b1;
                        fill_reg    <= '0;
                        cnt_reg     <= 7'd1;
                    end
                    else if (pad_reg)
                    begin
                        // message ended on a full block: 0x80 and length in a fresh one
                        len_blk_reg <= 1'b1;
                    end
                end
                sha256_pkg::ST_EMIT:
                begin
                    if (out_valid_reg && out_ready)
                    begin
                        emit_reg <= emit_reg + 3'd1;
                        if (emit_reg == 3'd7)
                        begin
                            out_valid_reg <= 1'b0;
                            len_blk_reg   <= 1'b0;
                            fill_reg      <= '0;
                            len_reg       <= '0;
                            for (int k = 0; k < 8; k++)
                            begin
                                hash_reg[k] <= sha256_pkg::init_hash(3'(k));
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // schedule window shift line, filled during rounds
    always_ff @(posedge clk)
    begin
        if (round_step)
        begin
            for (int k = 0; k < 15; k++)
            begin
                win_reg[k] <= win_reg[k+1];
            end
            win_reg[15] <= w_cur;
        end
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = hash_reg[emit_reg];
    assign word_index  = emit_reg;
    assign last_word   = (emit_reg == 3'd7);

endmodule
